### rtl/core/sip_pkg.sv
`timescale 1ns / 1ps
package sip_pkg;

  localparam int STATUS_W = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_NONE     = 2'd0,
    ST_POINT    = 2'd1,
    ST_PARALLEL = 2'd2
  } status_t;

endpackage

### rtl/core/segment_intersection_point_top.sv
`timescale 1ns / 1ps
// Contact test and crossing point of segments AB and CD. One pair is taken every cycle
// (busy stays low) and its result appears as a one-cycle out_valid beat after passing
// through seven arithmetic stages (differences, products, sums, contact test and
// split numerator products, numerator products, numerator difference, magnitudes), then
// one stage per quotient bit of the two restoring dividers for x and y, then the output
// register. The receiver cannot stall, so every beat must be taken in the cycle it is
// shown. The point is truncated toward zero; hit_x and hit_y are zero unless status is 1.
module segment_intersection_point_top #(
  parameter int COORD_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [COORD_BITS-1:0]       in_a_x,
  input  logic signed [COORD_BITS-1:0]       in_a_y,
  input  logic signed [COORD_BITS-1:0]       in_b_x,
  input  logic signed [COORD_BITS-1:0]       in_b_y,
  input  logic signed [COORD_BITS-1:0]       in_c_x,
  input  logic signed [COORD_BITS-1:0]       in_c_y,
  input  logic signed [COORD_BITS-1:0]       in_d_x,
  input  logic signed [COORD_BITS-1:0]       in_d_y,
  output logic                               out_valid,
  output logic [sip_pkg::STATUS_W-1:0]       out_status,
  output logic signed [COORD_BITS-1:0]       out_hit_x,
  output logic signed [COORD_BITS-1:0]       out_hit_y
);
  import sip_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int D  = CB + 1;
  localparam int P  = 2 * D;
  localparam int Q  = 2 * D + 1;
  localparam int NW = D + Q;
  localparam int QL = (Q + 1) / 2;
  localparam int QH = Q - QL;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // stage 1: differences
  logic v1_r;
  logic signed [D-1:0] cdx_r, cdy_r, cax_r, cay_r, cbx_r, cby_r;
  logic signed [D-1:0] abx_r, aby_r, acx_r, acy_r, adx_r, ady_r;
  logic signed [CB-1:0] ax1_r, ay1_r, cx1_r, cy1_r;
  logic ab_z1_r, cd_z1_r, a_eq_c1_r, b_eq_c1_r, d_eq_a1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else v1_r <= accept;
  end

  always_ff @(posedge clk) begin
    cdx_r <= {in_d_x[CB-1], in_d_x} - {in_c_x[CB-1], in_c_x};
    cdy_r <= {in_d_y[CB-1], in_d_y} - {in_c_y[CB-1], in_c_y};
    cax_r <= {in_a_x[CB-1], in_a_x} - {in_c_x[CB-1], in_c_x};
    cay_r <= {in_a_y[CB-1], in_a_y} - {in_c_y[CB-1], in_c_y};
    cbx_r <= {in_b_x[CB-1], in_b_x} - {in_c_x[CB-1], in_c_x};
    cby_r <= {in_b_y[CB-1], in_b_y} - {in_c_y[CB-1], in_c_y};
    abx_r <= {in_b_x[CB-1], in_b_x} - {in_a_x[CB-1], in_a_x};
    aby_r <= {in_b_y[CB-1], in_b_y} - {in_a_y[CB-1], in_a_y};
    acx_r <= {in_c_x[CB-1], in_c_x} - {in_a_x[CB-1], in_a_x};
    acy_r <= {in_c_y[CB-1], in_c_y} - {in_a_y[CB-1], in_a_y};
    adx_r <= {in_d_x[CB-1], in_d_x} - {in_a_x[CB-1], in_a_x};
    ady_r <= {in_d_y[CB-1], in_d_y} - {in_a_y[CB-1], in_a_y};
    ax1_r <= in_a_x;
    ay1_r <= in_a_y;
    cx1_r <= in_c_x;
    cy1_r <= in_c_y;
    ab_z1_r   <= (in_a_x == in_b_x) && (in_a_y == in_b_y);
    cd_z1_r   <= (in_c_x == in_d_x) && (in_c_y == in_d_y);
    a_eq_c1_r <= (in_a_x == in_c_x) && (in_a_y == in_c_y);
    b_eq_c1_r <= (in_b_x == in_c_x) && (in_b_y == in_c_y);
    d_eq_a1_r <= (in_d_x == in_a_x) && (in_d_y == in_a_y);
  end

  // stage 2: products
  logic v2_r;
  logic signed [P-1:0] o1p_r, o1n_r, o2p_r, o2n_r, o3p_r, o3n_r, o4p_r, o4n_r;
  logic signed [P-1:0] dap_r, daq_r, dbp_r, dbq_r, dcp_r, dcq_r, ddp_r, ddq_r;
  logic signed [P-1:0] lcx_r, lcy_r, lax_r, lay_r;
  logic signed [P-1:0] detp_r, detn_r, c1p_r, c1n_r, c2p_r, c2n_r;
  logic signed [D-1:0] abx2_r, aby2_r, cdx2_r, cdy2_r;
  logic ab_z2_r, cd_z2_r, a_eq_c2_r, b_eq_c2_r, d_eq_a2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    o1p_r  <= cdx_r * cay_r;
    o1n_r  <= cdy_r * cax_r;
    o2p_r  <= cdx_r * cby_r;
    o2n_r  <= cdy_r * cbx_r;
    o3p_r  <= abx_r * acy_r;
    o3n_r  <= aby_r * acx_r;
    o4p_r  <= abx_r * ady_r;
    o4n_r  <= aby_r * adx_r;
    dap_r  <= cdx_r * cax_r;
    daq_r  <= cdy_r * cay_r;
    dbp_r  <= cdx_r * cbx_r;
    dbq_r  <= cdy_r * cby_r;
    dcp_r  <= abx_r * acx_r;
    dcq_r  <= aby_r * acy_r;
    ddp_r  <= abx_r * adx_r;
    ddq_r  <= aby_r * ady_r;
    lcx_r  <= cdx_r * cdx_r;
    lcy_r  <= cdy_r * cdy_r;
    lax_r  <= abx_r * abx_r;
    lay_r  <= aby_r * aby_r;
    detp_r <= abx_r * cdy_r;
    detn_r <= aby_r * cdx_r;
    c1p_r  <= aby_r * ax1_r;
    c1n_r  <= abx_r * ay1_r;
    c2p_r  <= cdy_r * cx1_r;
    c2n_r  <= cdx_r * cy1_r;
    abx2_r <= abx_r;
    aby2_r <= aby_r;
    cdx2_r <= cdx_r;
    cdy2_r <= cdy_r;
    ab_z2_r   <= ab_z1_r;
    cd_z2_r   <= cd_z1_r;
    a_eq_c2_r <= a_eq_c1_r;
    b_eq_c2_r <= b_eq_c1_r;
    d_eq_a2_r <= d_eq_a1_r;
  end

  // stage 3: sums
  logic v3_r;
  logic signed [Q-1:0] o1_r, o2_r, o3_r, o4_r, da_r, db_r, dc_r, dd_r;
  logic signed [Q-1:0] lcd_r, lab_r, det3_r, c1_r, c2_r;
  logic signed [D-1:0] abx3_r, aby3_r, cdx3_r, cdy3_r;
  logic ab_z3_r, cd_z3_r, a_eq_c3_r, b_eq_c3_r, d_eq_a3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    o1_r   <= o1p_r - o1n_r;
    o2_r   <= o2p_r - o2n_r;
    o3_r   <= o3p_r - o3n_r;
    o4_r   <= o4p_r - o4n_r;
    da_r   <= dap_r + daq_r;
    db_r   <= dbp_r + dbq_r;
    dc_r   <= dcp_r + dcq_r;
    dd_r   <= ddp_r + ddq_r;
    lcd_r  <= lcx_r + lcy_r;
    lab_r  <= lax_r + lay_r;
    det3_r <= detp_r - detn_r;
    c1_r   <= c1p_r - c1n_r;
    c2_r   <= c2p_r - c2n_r;
    abx3_r <= abx2_r;
    aby3_r <= aby2_r;
    cdx3_r <= cdx2_r;
    cdy3_r <= cdy2_r;
    ab_z3_r   <= ab_z2_r;
    cd_z3_r   <= cd_z2_r;
    a_eq_c3_r <= a_eq_c2_r;
    b_eq_c3_r <= b_eq_c2_r;
    d_eq_a3_r <= d_eq_a2_r;
  end

  // stage 4: contact test and split numerator products
  logic signed [Q:0] ra, rb, rc, rd;
  logic pos1, pos2, pos3, pos4, on_a, on_b, on_c, on_d, touch_nxt;
  logic signed [QL:0]   c1l, c2l;
  logic signed [QH-1:0] c1h, c2h;

  always_comb begin
    ra   = lcd_r - da_r;
    rb   = lcd_r - db_r;
    rc   = lab_r - dc_r;
    rd   = lab_r - dd_r;
    pos1 = !o1_r[Q-1] && (o1_r != '0);
    pos2 = !o2_r[Q-1] && (o2_r != '0);
    pos3 = !o3_r[Q-1] && (o3_r != '0);
    pos4 = !o4_r[Q-1] && (o4_r != '0);
    on_a = cd_z3_r ? a_eq_c3_r : ((o1_r == '0) && !da_r[Q-1] && !ra[Q]);
    on_b = cd_z3_r ? b_eq_c3_r : ((o2_r == '0) && !db_r[Q-1] && !rb[Q]);
    on_c = ab_z3_r ? a_eq_c3_r : ((o3_r == '0) && !dc_r[Q-1] && !rc[Q]);
    on_d = ab_z3_r ? d_eq_a3_r : ((o4_r == '0) && !dd_r[Q-1] && !rd[Q]);
    touch_nxt = ((pos1 != pos2) && (pos3 != pos4)) || on_a || on_b || on_c || on_d;
    c1l  = $signed({1'b0, c1_r[QL-1:0]});
    c2l  = $signed({1'b0, c2_r[QL-1:0]});
    c1h  = $signed(c1_r[Q-1:QL]);
    c2h  = $signed(c2_r[Q-1:QL]);
  end

  logic v4_r, touch4_r;
  logic signed [D+QL:0]   xpl_r, xnl_r, ypl_r, ynl_r;
  logic signed [D+QH-1:0] xph_r, xnh_r, yph_r, ynh_r;
  logic signed [Q-1:0] det4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else v4_r <= v3_r;
  end

  always_ff @(posedge clk) begin
    touch4_r <= touch_nxt;
    xpl_r    <= abx3_r * c2l;
    xph_r    <= abx3_r * c2h;
    xnl_r    <= cdx3_r * c1l;
    xnh_r    <= cdx3_r * c1h;
    ypl_r    <= aby3_r * c2l;
    yph_r    <= aby3_r * c2h;
    ynl_r    <= cdy3_r * c1l;
    ynh_r    <= cdy3_r * c1h;
    det4_r   <= det3_r;
  end

  // stage 5: numerator products and status
  logic v5_r;
  logic signed [NW-1:0] nxp_r, nxn_r, nyp_r, nyn_r;
  logic signed [Q-1:0] det5_r;
  status_t st5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else v5_r <= v4_r;
  end

  always_ff @(posedge clk) begin
    nxp_r  <= (NW'(xph_r) << QL) + NW'(xpl_r);
    nxn_r  <= (NW'(xnh_r) << QL) + NW'(xnl_r);
    nyp_r  <= (NW'(yph_r) << QL) + NW'(ypl_r);
    nyn_r  <= (NW'(ynh_r) << QL) + NW'(ynl_r);
    det5_r <= det4_r;
    if (!touch4_r) st5_r <= ST_NONE;
    else if (det4_r == '0) st5_r <= ST_PARALLEL;
    else st5_r <= ST_POINT;
  end

  // stage 6: numerators
  logic v6_r;
  logic signed [NW-1:0] nx6_r, ny6_r;
  logic signed [Q-1:0] det6_r;
  status_t st6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else v6_r <= v5_r;
  end

  always_ff @(posedge clk) begin
    nx6_r  <= nxp_r - nxn_r;
    ny6_r  <= nyp_r - nyn_r;
    det6_r <= det5_r;
    st6_r  <= st5_r;
  end

  // stage 7 and divider stages
  logic            dv_v_r   [CB+1];
  status_t         dv_st_r  [CB+1];
  logic            dv_ngx_r [CB+1];
  logic            dv_ngy_r [CB+1];
  logic [Q-1:0]    dv_d_r   [CB+1];
  logic [NW-1:0]   dv_rx_r  [CB+1];
  logic [NW-1:0]   dv_ry_r  [CB+1];
  logic [CB-1:0]   dv_qx_r  [CB+1];
  logic [CB-1:0]   dv_qy_r  [CB+1];

  always_ff @(posedge clk) begin
    if (!rst_n) dv_v_r[0] <= 1'b0;
    else dv_v_r[0] <= v6_r;
  end

  always_ff @(posedge clk) begin
    dv_st_r[0]  <= st6_r;
    dv_ngx_r[0] <= nx6_r[NW-1] != det6_r[Q-1];
    dv_ngy_r[0] <= ny6_r[NW-1] != det6_r[Q-1];
    dv_d_r[0]   <= det6_r[Q-1] ? Q'(-det6_r) : Q'(det6_r);
    dv_rx_r[0]  <= nx6_r[NW-1] ? NW'(-nx6_r) : NW'(nx6_r);
    dv_ry_r[0]  <= ny6_r[NW-1] ? NW'(-ny6_r) : NW'(ny6_r);
    dv_qx_r[0]  <= '0;
    dv_qy_r[0]  <= '0;
  end

  for (genvar k = 0; k < CB; k++) begin : g_div
    localparam int BIT = CB - 1 - k;
    logic [NW-1:0] dsh;
    logic [NW:0]   tx, ty;

    always_comb begin
      dsh = NW'(dv_d_r[k]) << BIT;
      tx  = {1'b0, dv_rx_r[k]} - {1'b0, dsh};
      ty  = {1'b0, dv_ry_r[k]} - {1'b0, dsh};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) dv_v_r[k+1] <= 1'b0;
      else dv_v_r[k+1] <= dv_v_r[k];
    end

    always_ff @(posedge clk) begin
      dv_st_r[k+1]  <= dv_st_r[k];
      dv_ngx_r[k+1] <= dv_ngx_r[k];
      dv_ngy_r[k+1] <= dv_ngy_r[k];
      dv_d_r[k+1]   <= dv_d_r[k];
      dv_rx_r[k+1]  <= tx[NW] ? dv_rx_r[k] : tx[NW-1:0];
      dv_ry_r[k+1]  <= ty[NW] ? dv_ry_r[k] : ty[NW-1:0];
      dv_qx_r[k+1]  <= dv_qx_r[k] | (CB'(!tx[NW]) << BIT);
      dv_qy_r[k+1]  <= dv_qy_r[k] | (CB'(!ty[NW]) << BIT);
    end
  end

  // output beat
  logic out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic signed [CB-1:0] out_hit_x_r, out_hit_y_r;
  logic point_o;

  assign point_o = dv_v_r[CB] && (dv_st_r[CB] == ST_POINT);

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= dv_v_r[CB];
  end

  always_ff @(posedge clk) begin
    out_status_r <= dv_v_r[CB] ? dv_st_r[CB] : ST_NONE;
    out_hit_x_r  <= !point_o ? '0 : (dv_ngx_r[CB] ? -dv_qx_r[CB] : dv_qx_r[CB]);
    out_hit_y_r  <= !point_o ? '0 : (dv_ngy_r[CB] ? -dv_qy_r[CB] : dv_qy_r[CB]);
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_hit_x  = out_hit_x_r;
  assign out_hit_y  = out_hit_y_r;

  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(dv_v_r[0], CB + 1))
    else $error("beat without matching entry into the divider");

  a_nopt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_POINT)) |-> (out_hit_x == '0 && out_hit_y == '0))
    else $error("point reported without contact");

  a_st: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_NONE || out_status == ST_POINT ||
                   out_status == ST_PARALLEL))
    else $error("bad status code");

  a_par: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_v_r[0] && dv_st_r[0] == ST_POINT) |-> (dv_d_r[0] != '0))
    else $error("point status with zero determinant");
endmodule
